// ===== rtl/core/mqrf_pkg.sv =====
// shared types and constants for the multi-queue ring fifo manager
// command and status codes, field widths, parameter defaults and the sequencer states
// no dependencies
package mqrf_pkg;

  localparam int CMD_W   = 2;
  localparam int QNUM_W  = 3;
  localparam int CAP_W   = 5;
  localparam int DATA_W  = 32;
  localparam int STAT_W  = 3;

  localparam int NUM_QUEUES_DEF  = 8;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int WORD_WIDTH_DEF  = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOCATE = 2'd0,
    CMD_ENQUEUE  = 2'd1,
    CMD_DEQUEUE  = 2'd2,
    CMD_RELEASE  = 2'd3
  } command_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 3'd0,
    ST_NO_FREE = 3'd1,
    ST_UNUSED  = 3'd2,
    ST_FULL    = 3'd3,
    ST_EMPTY   = 3'd4,
    ST_BAD_CAP = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SEQ_IDLE,
    SEQ_EXEC,
    SEQ_DONE
  } state_t;

endpackage

// ===== rtl/core/multi_queue_ring_fifo_manager.sv =====
// multi-queue ring fifo manager: a request passes through the sequencer states
// exec and done before its response (longer while the response is stalled); the
// next request is taken only back in idle, after the read-modify-write of the
// descriptor memory and the registered read of the entry store. rst clears the
// in-use flags, the sequencer and response valid; neither memory is cleared.
// depends on mqrf_pkg and mqrf_free_search
module multi_queue_ring_fifo_manager
  import mqrf_pkg::*;
#(
  parameter int NUM_QUEUES  = NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int WORD_WIDTH  = WORD_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  logic [CMD_W-1:0]  command,
  input  logic [QNUM_W-1:0] queue_number,
  input  logic [CAP_W-1:0]  capacity,
  input  logic [DATA_W-1:0] data_in,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output logic [STAT_W-1:0] status,
  output logic [QNUM_W-1:0] queue_out,
  output logic [DATA_W-1:0] data_out
);

  localparam int QIDX_W   = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int PTR_W    = $clog2(QUEUE_DEPTH);
  localparam int FILL_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W    = (FILL_W > CAP_W) ? FILL_W : CAP_W;
  localparam int DESC_W   = CAP_W + 2 * PTR_W + FILL_W;
  localparam int ENTRIES  = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ENTRY_AW = $clog2(ENTRIES);
  localparam int XW       = (WORD_WIDTH > DATA_W) ? WORD_WIDTH : DATA_W;
  // descriptor layout: capacity | read pointer | write pointer | fill count
  localparam int FILL_LO  = 0;
  localparam int WP_LO    = FILL_W;
  localparam int RP_LO    = FILL_W + PTR_W;
  localparam int CAP_LO   = FILL_W + 2 * PTR_W;

  state_t state, state_next;

  logic [NUM_QUEUES-1:0] in_use;
  logic [NUM_QUEUES-1:0] in_use_next;

  command_t              cmd;
  logic [QNUM_W-1:0]     qn;
  logic [CAP_W-1:0]      cap_req;
  logic [WORD_WIDTH-1:0] word;
  logic                  deq_ok;
  logic                  deq_ok_next;
  status_t               res_status;
  status_t               res_status_next;
  logic [QNUM_W-1:0]     res_queue;
  logic [QNUM_W-1:0]     res_queue_next;

  logic [DESC_W-1:0]     desc_mem [NUM_QUEUES];
  logic [DESC_W-1:0]     desc_rd;
  logic                  desc_re;
  logic [QIDX_W-1:0]     desc_raddr;
  logic                  desc_we;
  logic [QIDX_W-1:0]     desc_waddr;
  logic [DESC_W-1:0]     desc_wdata;

  logic [WORD_WIDTH-1:0] entry_mem [ENTRIES];
  logic [WORD_WIDTH-1:0] entry_rd;
  logic                  entry_we;
  logic                  entry_re;
  logic [ENTRY_AW-1:0]   entry_addr;

  logic                  accept;
  logic                  rsp_load;
  logic                  in_range_req;
  logic                  q_ok;
  logic [QIDX_W-1:0]     q_idx;
  logic                  free_found;
  logic [QIDX_W-1:0]     free_idx;
  logic                  bad_cap;

  logic [CAP_W-1:0]      d_cap;
  logic [PTR_W-1:0]      d_rp;
  logic [PTR_W-1:0]      d_wp;
  logic [FILL_W-1:0]     d_fill;
  logic [FILL_W-1:0]     wp_inc;
  logic [FILL_W-1:0]     rp_inc;
  logic [PTR_W-1:0]      wp_adv;
  logic [PTR_W-1:0]      rp_adv;

  logic [XW-1:0]         word_ext;
  logic [XW-1:0]         rd_ext;

  mqrf_free_search #(
    .NUM_QUEUES (NUM_QUEUES),
    .QIDX_W     (QIDX_W)
  ) u_free_search (
    .in_use   (in_use),
    .found    (free_found),
    .free_idx (free_idx)
  );

  assign accept    = (state == SEQ_IDLE) && req_valid;
  assign req_stall = (state != SEQ_IDLE);
  assign rsp_load  = (state == SEQ_DONE) && (!rsp_valid || !rsp_stall);

  assign word_ext = XW'(data_in);

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= command_t'(command);
      qn      <= queue_number;
      cap_req <= capacity;
      word    <= word_ext[WORD_WIDTH-1:0];
    end
  end

  // descriptor read is issued with the request transaction
  assign in_range_req = 32'(queue_number) < NUM_QUEUES;
  assign desc_re      = accept;
  assign desc_raddr   = in_range_req ? QIDX_W'(queue_number) : '0;

  always_ff @(posedge clk) begin
    if (desc_re) begin
      desc_rd <= desc_mem[desc_raddr];
    end
    if (desc_we) begin
      desc_mem[desc_waddr] <= desc_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_re) begin
      entry_rd <= entry_mem[entry_addr];
    end
    if (entry_we) begin
      entry_mem[entry_addr] <= word;
    end
  end

  assign d_cap  = desc_rd[CAP_LO +: CAP_W];
  assign d_rp   = desc_rd[RP_LO +: PTR_W];
  assign d_wp   = desc_rd[WP_LO +: PTR_W];
  assign d_fill = desc_rd[FILL_LO +: FILL_W];

  // pointers wrap to zero at the queue's own capacity
  assign wp_inc = FILL_W'(d_wp) + FILL_W'(1);
  assign rp_inc = FILL_W'(d_rp) + FILL_W'(1);
  assign wp_adv = (CMP_W'(wp_inc) >= CMP_W'(d_cap)) ? '0 : wp_inc[PTR_W-1:0];
  assign rp_adv = (CMP_W'(rp_inc) >= CMP_W'(d_cap)) ? '0 : rp_inc[PTR_W-1:0];

  assign q_idx   = QIDX_W'(qn);
  assign q_ok    = (32'(qn) < NUM_QUEUES) && in_use[q_idx];
  assign bad_cap = (cap_req == '0) || (32'(cap_req) > QUEUE_DEPTH);

  always_comb begin
    in_use_next     = in_use;
    res_status_next = res_status;
    res_queue_next  = res_queue;
    deq_ok_next     = deq_ok;
    desc_we         = 1'b0;
    desc_waddr      = q_idx;
    desc_wdata      = desc_rd;
    entry_we        = 1'b0;
    entry_re        = 1'b0;
    entry_addr      = ENTRY_AW'(32'(q_idx) * QUEUE_DEPTH + 32'(d_wp));
    if (state == SEQ_EXEC) begin
      res_status_next = ST_OK;
      res_queue_next  = qn;
      deq_ok_next     = 1'b0;
      unique case (cmd)
        CMD_ALLOCATE: begin
          priority if (bad_cap) begin
            res_status_next = ST_BAD_CAP;
          end else if (!free_found) begin
            res_status_next = ST_NO_FREE;
          end else begin
            in_use_next[free_idx] = 1'b1;
            desc_we        = 1'b1;
            desc_waddr     = free_idx;
            desc_wdata     = '0;
            desc_wdata[CAP_LO +: CAP_W] = cap_req;
            res_queue_next = QNUM_W'(32'(free_idx));
          end
        end
        CMD_ENQUEUE: begin
          priority if (!q_ok) begin
            res_status_next = ST_UNUSED;
          end else if (CMP_W'(d_fill) >= CMP_W'(d_cap)) begin
            res_status_next = ST_FULL;
          end else begin
            entry_we = 1'b1;
            desc_we  = 1'b1;
            desc_wdata[WP_LO +: PTR_W]    = wp_adv;
            desc_wdata[FILL_LO +: FILL_W] = d_fill + FILL_W'(1);
          end
        end
        CMD_DEQUEUE: begin
          entry_addr = ENTRY_AW'(32'(q_idx) * QUEUE_DEPTH + 32'(d_rp));
          priority if (!q_ok) begin
            res_status_next = ST_UNUSED;
          end else if (d_fill == '0) begin
            res_status_next = ST_EMPTY;
          end else begin
            entry_re    = 1'b1;
            deq_ok_next = 1'b1;
            desc_we     = 1'b1;
            desc_wdata[RP_LO +: PTR_W]    = rp_adv;
            desc_wdata[FILL_LO +: FILL_W] = d_fill - FILL_W'(1);
          end
        end
        CMD_RELEASE: begin
          if (!q_ok) begin
            res_status_next = ST_UNUSED;
          end else begin
            in_use_next[q_idx] = 1'b0;
          end
        end
        default: begin
          res_status_next = ST_UNUSED;
        end
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: begin
        if (accept) state_next = SEQ_EXEC;
      end
      SEQ_EXEC: begin
        state_next = SEQ_DONE;
      end
      SEQ_DONE: begin
        if (rsp_load) state_next = SEQ_IDLE;
      end
      default: begin
        state_next = SEQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= SEQ_IDLE;
      in_use <= '0;
    end else begin
      state  <= state_next;
      in_use <= in_use_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_queue  <= res_queue_next;
    deq_ok     <= deq_ok_next;
  end

  // response register, entry read data holds until the next transaction
  assign rd_ext = XW'(entry_rd);

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status    <= res_status;
      queue_out <= res_queue;
      data_out  <= deq_ok ? rd_ext[DATA_W-1:0] : '0;
    end
  end

endmodule

// ===== rtl/core/mqrf_free_search.sv =====
// lowest-numbered free queue search over the in-use flags
// depends on mqrf_pkg only for the default of NUM_QUEUES
module mqrf_free_search
  import mqrf_pkg::*;
#(
  parameter int NUM_QUEUES = NUM_QUEUES_DEF,
  parameter int QIDX_W     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1
) (
  input  logic [NUM_QUEUES-1:0] in_use,
  output logic                  found,
  output logic [QIDX_W-1:0]     free_idx
);

  // scan downwards so the lowest free queue wins
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = NUM_QUEUES - 1; i >= 0; i--) begin
      if (!in_use[i]) begin
        found    = 1'b1;
        free_idx = QIDX_W'(i);
      end
    end
  end

endmodule

// ===== tb/multi_queue_ring_fifo_manager_tb.sv =====
// self-checking testbench for the multi-queue ring fifo manager: a directed table
// followed by random queue traffic, each response checked against its typed value or a behavioural model
// depends on mqrf_pkg and multi_queue_ring_fifo_manager
module multi_queue_ring_fifo_manager_tb;
  import mqrf_pkg::*;

  localparam int NQ          = NUM_QUEUES_DEF;
  localparam int DEPTH       = QUEUE_DEPTH_DEF;
  localparam int RANDOM_OPS  = 1680;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 12;

  typedef struct {
    command_t          cmd;
    logic [QNUM_W-1:0] qnum;
    logic [CAP_W-1:0]  cap;
    logic [DATA_W-1:0] word;
  } queue_req_t;

  typedef struct {
    status_t           st;
    logic [QNUM_W-1:0] qnum;
    logic [DATA_W-1:0] word;
  } queue_rsp_t;

  // one row of the directed table; known is set where the response is typed in
  typedef struct {
    command_t    cmd;
    int          qnum;
    int          cap;
    logic [31:0] word;
    bit          known;
    status_t     st;
    int          qout;
    logic [31:0] dout;
  } directed_row_t;

  localparam int N_DIRECTED = 26;

  directed_row_t directed_rows [N_DIRECTED] = '{
    '{CMD_ENQUEUE,  0,  0, 32'h0000_0000, 1'b1, ST_UNUSED,  0, 32'h0},
    '{CMD_DEQUEUE,  7,  0, 32'h0000_0000, 1'b1, ST_UNUSED,  7, 32'h0},
    '{CMD_RELEASE,  3,  0, 32'h0000_0000, 1'b1, ST_UNUSED,  3, 32'h0},
    '{CMD_ALLOCATE, 5,  0, 32'h0000_0000, 1'b1, ST_BAD_CAP, 5, 32'h0},
    '{CMD_ALLOCATE, 2, 17, 32'h0000_0000, 1'b1, ST_BAD_CAP, 2, 32'h0},
    '{CMD_ALLOCATE, 7, 31, 32'hFFFF_FFFF, 1'b1, ST_BAD_CAP, 7, 32'h0},
    '{CMD_ALLOCATE, 6,  1, 32'h0000_0000, 1'b1, ST_OK,      0, 32'h0},
    '{CMD_DEQUEUE,  0,  0, 32'h0000_0000, 1'b1, ST_EMPTY,   0, 32'h0},
    '{CMD_ENQUEUE,  0,  0, 32'hFFFF_FFFF, 1'b1, ST_OK,      0, 32'h0},
    '{CMD_ENQUEUE,  0, 31, 32'h0000_0000, 1'b1, ST_FULL,    0, 32'h0},
    '{CMD_DEQUEUE,  0,  0, 32'h0000_0000, 1'b1, ST_OK,      0, 32'hFFFF_FFFF},
    '{CMD_ALLOCATE, 0, 16, 32'h0000_0000, 1'b1, ST_OK,      1, 32'h0},
    '{CMD_ALLOCATE, 3,  2, 32'h0000_0000, 1'b1, ST_OK,      2, 32'h0},
    '{CMD_ALLOCATE, 3,  3, 32'h0000_0000, 1'b1, ST_OK,      3, 32'h0},
    '{CMD_ALLOCATE, 1,  5, 32'h0000_0000, 1'b1, ST_OK,      4, 32'h0},
    '{CMD_ALLOCATE, 1,  8, 32'h0000_0000, 1'b1, ST_OK,      5, 32'h0},
    '{CMD_ALLOCATE, 2, 13, 32'h0000_0000, 1'b1, ST_OK,      6, 32'h0},
    '{CMD_ALLOCATE, 0, 15, 32'h0000_0000, 1'b1, ST_OK,      7, 32'h0},
    '{CMD_ALLOCATE, 4,  9, 32'h0000_0000, 1'b1, ST_NO_FREE, 4, 32'h0},
    '{CMD_ENQUEUE,  1,  0, 32'hA5A5_A5A5, 1'b0, ST_OK,      0, 32'h0},
    '{CMD_ENQUEUE,  1,  0, 32'h5A5A_5A5A, 1'b0, ST_OK,      0, 32'h0},
    '{CMD_DEQUEUE,  1,  0, 32'h0000_0000, 1'b0, ST_OK,      0, 32'h0},
    '{CMD_RELEASE,  1,  0, 32'h0000_0000, 1'b1, ST_OK,      1, 32'h0},
    '{CMD_ALLOCATE, 6,  4, 32'h0000_0000, 1'b1, ST_OK,      1, 32'h0},
    '{CMD_RELEASE,  0,  0, 32'h0000_0000, 1'b1, ST_OK,      0, 32'h0},
    '{CMD_ENQUEUE,  0,  0, 32'h0000_0001, 1'b1, ST_UNUSED,  0, 32'h0}
  };

  logic              clk;
  logic              rst = 1'b1;
  logic              req_valid = 1'b0;
  logic              req_stall;
  logic [CMD_W-1:0]  command = '0;
  logic [QNUM_W-1:0] queue_number = '0;
  logic [CAP_W-1:0]  capacity = '0;
  logic [DATA_W-1:0] data_in = '0;
  logic              rsp_valid;
  logic              rsp_stall = 1'b0;
  logic [STAT_W-1:0] status;
  logic [QNUM_W-1:0] queue_out;
  logic [DATA_W-1:0] data_out;

  // shadow copy of the queue descriptors and entry store
  bit          q_used [NQ];
  int          q_cap  [NQ];
  int          q_rd   [NQ];
  int          q_wr   [NQ];
  int          q_fill [NQ];
  logic [31:0] q_words [NQ][DEPTH];

  queue_rsp_t pending_responses [$];
  bit         steady = 1'b0;
  bit         stim_done = 1'b0;
  int         error_count = 0;
  int         req_count = 0;
  int         rsp_count = 0;
  int         status_tally [6];
  int         cycle_count = 0;

  multi_queue_ring_fifo_manager DUT (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .command     (command),
    .queue_number(queue_number),
    .capacity    (capacity),
    .data_in     (data_in),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .status      (status),
    .queue_out   (queue_out),
    .data_out    (data_out)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int wrap_next(int ptr, int cap);
    return (ptr + 1 >= cap) ? 0 : ptr + 1;
  endfunction

  // applies one command to the shadow state and returns the response it gives
  function automatic queue_rsp_t apply_queue_command(queue_req_t r);
    queue_rsp_t rsp;
    int         qn;
    bit         found;
    qn = r.qnum;
    rsp.st = ST_OK;
    rsp.qnum = r.qnum;
    rsp.word = '0;
    if (r.cmd == CMD_ALLOCATE) begin
      if (r.cap == 0 || r.cap > DEPTH) begin
        rsp.st = ST_BAD_CAP;
      end else begin
        found = 1'b0;
        for (int i = 0; i < NQ; i++) begin
          if (!found && !q_used[i]) begin
            found = 1'b1;
            q_used[i] = 1'b1;
            q_cap[i] = r.cap;
            q_rd[i] = 0;
            q_wr[i] = 0;
            q_fill[i] = 0;
            rsp.qnum = QNUM_W'(i);
          end
        end
        if (!found) rsp.st = ST_NO_FREE;
      end
    end else if (qn >= NQ || !q_used[qn]) begin
      rsp.st = ST_UNUSED;
    end else if (r.cmd == CMD_ENQUEUE) begin
      if (q_fill[qn] >= q_cap[qn]) begin
        rsp.st = ST_FULL;
      end else begin
        q_words[qn][q_wr[qn]] = r.word;
        q_wr[qn] = wrap_next(q_wr[qn], q_cap[qn]);
        q_fill[qn]++;
      end
    end else if (r.cmd == CMD_DEQUEUE) begin
      if (q_fill[qn] == 0) begin
        rsp.st = ST_EMPTY;
      end else begin
        rsp.word = q_words[qn][q_rd[qn]];
        q_rd[qn] = wrap_next(q_rd[qn], q_cap[qn]);
        q_fill[qn]--;
      end
    end else begin
      q_used[qn] = 1'b0;
    end
    return rsp;
  endfunction

  function automatic logic [QNUM_W-1:0] pick_queue();
    bit any_used;
    int qn;
    any_used = 1'b0;
    for (int i = 0; i < NQ; i++) any_used |= q_used[i];
    qn = $urandom_range(0, NQ - 1);
    // mostly aim at a live queue so the traffic gets past the unused check
    if (any_used && $urandom_range(0, 9) != 0) begin
      while (!q_used[qn]) qn = $urandom_range(0, NQ - 1);
    end
    return QNUM_W'(qn);
  endfunction

  function automatic queue_req_t random_queue_command(bit filling);
    queue_req_t r;
    int         roll;
    roll = $urandom_range(0, 99);
    r.qnum = pick_queue();
    r.cap = CAP_W'($urandom_range(0, 31));
    r.word = $urandom;
    if (roll < 7) begin
      r.cmd = CMD_ALLOCATE;
      r.qnum = QNUM_W'($urandom_range(0, NQ - 1));
      if ($urandom_range(0, 7) != 0) r.cap = CAP_W'($urandom_range(1, DEPTH));
    end else if (roll < 12) begin
      r.cmd = CMD_RELEASE;
    end else if (roll < (filling ? 70 : 40)) begin
      r.cmd = CMD_ENQUEUE;
    end else begin
      r.cmd = CMD_DEQUEUE;
    end
    return r;
  endfunction

  // drives one request transaction and records the response it should produce
  task automatic issue_request(queue_req_t r, bit known, queue_rsp_t typed);
    int         gap;
    queue_rsp_t predicted;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    command <= r.cmd;
    queue_number <= r.qnum;
    capacity <= r.cap;
    data_in <= r.word;
    do @(posedge clk); while (req_stall !== 1'b0);
    predicted = apply_queue_command(r);
    if (known) predicted = typed;
    pending_responses.push_back(predicted);
    status_tally[predicted.st]++;
    req_count++;
  endtask

  initial begin
    queue_req_t r;
    queue_rsp_t typed;
    for (int i = 0; i < NQ; i++) begin
      q_used[i] = 1'b0;
      q_cap[i] = 0;
      q_rd[i] = 0;
      q_wr[i] = 0;
      q_fill[i] = 0;
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) begin
      r.cmd = directed_rows[i].cmd;
      r.qnum = QNUM_W'(directed_rows[i].qnum);
      r.cap = CAP_W'(directed_rows[i].cap);
      r.word = directed_rows[i].word;
      typed.st = directed_rows[i].st;
      typed.qnum = QNUM_W'(directed_rows[i].qout);
      typed.word = directed_rows[i].dout;
      issue_request(r, directed_rows[i].known, typed);
    end
    for (int i = 0; i < RANDOM_OPS; i++) begin
      // alternate filling and draining phases so both full and empty turn up
      steady = ((i / 120) % 4) == 3;
      r = random_queue_command(((i / 90) % 2) == 0);
      issue_request(r, 1'b0, typed);
    end
    req_valid <= 1'b0;
    steady = 1'b0;
    while (pending_responses.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    stim_done = 1'b1;
  end

  // response side stall: outside the steady phase each transaction waits a random number of cycles first
  initial begin
    int w;
    @(negedge rst);
    forever begin
      w = steady ? 0 : $urandom_range(0, 7);
      if (w != 0) begin
        rsp_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      rsp_stall <= 1'b0;
      do @(posedge clk); while (!(rsp_valid === 1'b1 && rsp_stall === 1'b0));
    end
  end

  always @(posedge clk) begin
    queue_rsp_t want;
    if (!rst && rsp_valid !== 1'b0 && rsp_stall === 1'b0) begin
      rsp_count++;
      if (pending_responses.size() == 0) begin
        $display("%0t: response with none expected: status %0d queue %0d data %h",
                 $time, status, queue_out, data_out);
        error_count++;
      end else begin
        want = pending_responses.pop_front();
        if (rsp_valid !== 1'b1) begin
          $display("%0t: rsp_valid unknown, expected 1 actual %b", $time, rsp_valid);
          error_count++;
        end
        if (status !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status);
          error_count++;
        end
        if (queue_out !== want.qnum) begin
          $display("%0t: queue_out expected %0d actual %0d", $time, want.qnum, queue_out);
          error_count++;
        end
        if (data_out !== want.word) begin
          $display("%0t: data_out expected %h actual %h", $time, want.word, data_out);
          error_count++;
        end
      end
    end
  end

  initial begin
    while (!stim_done && cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    if (stim_done) begin
      $display("%0d requests and %0d responses in %0d cycles", req_count, rsp_count,
               cycle_count);
      $display("ok %0d, no free queue %0d, unused %0d, full %0d, empty %0d, bad capacity %0d",
               status_tally[ST_OK], status_tally[ST_NO_FREE], status_tally[ST_UNUSED],
               status_tally[ST_FULL], status_tally[ST_EMPTY], status_tally[ST_BAD_CAP]);
      if (error_count == 0 && pending_responses.size() == 0) begin
        $display("Simulation PASSED");
      end else begin
        $display("Simulation FAILED");
      end
    end else begin
      $display("timeout after %0d cycles, %0d responses outstanding", cycle_count,
               pending_responses.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
